// ===== hdl/f32e_pkg.sv =====
// Shared constants and sideband type for the binary32 exp pipeline.
// No dependencies; imported by the FMA unit and the top level.
package f32e_pkg;

  // fused multiply-add unit latency in register stages
  localparam int unsigned FmaLat = 6;
  // number of chained multiply-adds in the exp datapath
  localparam int unsigned NumFma = 11;

  localparam logic [31:0] F_MAGIC    = 32'h4B40_0000;
  localparam logic [31:0] F_ZERO_CUT = 32'hC2CF_F1B4;
  localparam logic [31:0] F_INF_CUT  = 32'h42B1_7217;
  localparam logic [31:0] F_LOG2E    = 32'h3FB8_AA3B;
  localparam logic [31:0] F_MLN2_HI  = 32'hBF31_7218;
  localparam logic [31:0] F_MLN2_LO  = 32'h3102_E308;
  localparam logic [31:0] F_C1       = 32'h3F7F_FFFB;
  localparam logic [31:0] F_C2       = 32'h3EFF_FEE3;
  localparam logic [31:0] F_C3       = 32'h3E2A_AD40;
  localparam logic [31:0] F_C4       = 32'h3D2B_9D0D;
  localparam logic [31:0] F_C5       = 32'h3C07_CFCE;
  localparam logic [31:0] F_ONE      = 32'h3F80_0000;
  localparam logic [31:0] F_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] F_PINF     = 32'h7F80_0000;
  localparam logic [31:0] F_QNAN_BIT = 32'h0040_0000;
  localparam logic [31:0] E_MIN      = 32'hC100_0000;
  localparam logic [31:0] E_MAX      = 32'h3F80_0000;

  // values that ride alongside the multiply-add chain
  typedef struct packed {
    logic [31:0] x;     // argument
    logic [31:0] v;     // n, debiased
    logic [31:0] t;     // reduced argument
    logic [31:0] p;     // polynomial
    logic [31:0] sn;    // scale factor, clamped part
    logic [31:0] so;    // scale factor, remainder part
    logic        last;
  } side_t;

endpackage

// ===== hdl/f32_exp_poly5.sv =====
// Top level of the binary32 exp(x) stream block.
// Depends on f32e_pkg and f32e_fma.
//
// f32_exp_poly5 takes one binary32 argument per transfer and returns exp(x), bit-exact to a
// fixed chain of eleven fused multiply-adds (round to nearest even, subnormals kept): rounding
// of x*log2e to n, split scale factors, two-part ln2 reduction, degree-5 Horner polynomial and
// reconstruction. NaN returns quieted, large negative arguments give +0, large positive give
// +inf. One transfer is accepted every cycle unless the output stalls; the datapath is eleven
// six-stage FMA units plus the output register. The whole pipeline advances together: it holds
// while the output register carries a result the sink has not taken, and s_axis_tready drops
// only then. tlast travels with its element.
module f32_exp_poly5 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] x_bits
  input  logic        s_axis_tlast,   // last_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] y_bits
  output logic        m_axis_tlast    // last_out
);
  import f32e_pkg::*;

  logic ce;
  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  // sideband and valid delay lines, one per FMA unit, matching its latency
  side_t side_q [NumFma][FmaLat];
  logic  vld_q  [NumFma][FmaLat];
  side_t side_in  [NumFma];
  side_t side_out [NumFma];
  logic  vld_in   [NumFma];
  logic  [31:0] op_a [NumFma];
  logic  [31:0] op_b [NumFma];
  logic  [31:0] op_c [NumFma];
  logic  [31:0] res  [NumFma];

  // scale factors from rounded n
  logic [31:0] eo, en, sn, so;
  always_comb begin
    eo = {res[0][8:0], 23'd0};
    en = eo;
    if ($signed(en) < $signed(E_MIN)) en = E_MIN;
    if ($signed(en) > $signed(E_MAX)) en = E_MAX;
    sn = en + F_ONE;
    so = (eo - en) + F_ONE;
  end

  always_comb begin
    for (int k = 0; k < NumFma; k++) begin
      side_out[k] = side_q[k][FmaLat-1];
    end
    side_in[0]      = '0;
    side_in[0].x    = s_axis_tdata;
    side_in[0].last = s_axis_tlast;
    vld_in[0]       = s_axis_tvalid;
    for (int k = 1; k < NumFma; k++) begin
      side_in[k] = side_out[k-1];
      vld_in[k]  = vld_q[k-1][FmaLat-1];
    end
    side_in[1].sn = sn;
    side_in[1].so = so;
    side_in[2].v  = res[1];
    side_in[4].t  = res[3];
    side_in[8].p  = res[7];

    // n = round(x*log2e) via magic bias
    op_a[0]  = s_axis_tdata;    op_b[0]  = F_LOG2E;         op_c[0]  = F_MAGIC;
    op_a[1]  = res[0];          op_b[1]  = F_ONE;           op_c[1]  = F_MAGIC | F_NEG_ZERO;
    // Cody-Waite reduction
    op_a[2]  = res[1];          op_b[2]  = F_MLN2_HI;       op_c[2]  = side_out[1].x;
    op_a[3]  = side_out[2].v;   op_b[3]  = F_MLN2_LO;       op_c[3]  = res[2];
    // Horner polynomial
    op_a[4]  = F_C5;            op_b[4]  = res[3];          op_c[4]  = F_C4;
    op_a[5]  = res[4];          op_b[5]  = side_out[4].t;   op_c[5]  = F_C3;
    op_a[6]  = res[5];          op_b[6]  = side_out[5].t;   op_c[6]  = F_C2;
    op_a[7]  = res[6];          op_b[7]  = side_out[6].t;   op_c[7]  = F_C1;
    // reconstruction
    op_a[8]  = side_out[7].t;   op_b[8]  = side_out[7].so;  op_c[8]  = F_NEG_ZERO;
    op_a[9]  = res[8];          op_b[9]  = side_out[8].p;   op_c[9]  = side_out[8].so;
    op_a[10] = side_out[9].sn;  op_b[10] = res[9];          op_c[10] = F_NEG_ZERO;
  end

  for (genvar k = 0; k < NumFma; k++) begin : g_fma
    f32e_fma u_fma (
      .clk_i (clk_i),
      .ce_i  (ce),
      .a_i   (op_a[k]),
      .b_i   (op_b[k]),
      .c_i   (op_c[k]),
      .z_o   (res[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumFma; k++) begin
        for (int s = 0; s < FmaLat; s++) vld_q[k][s] <= 1'b0;
      end
    end else if (ce) begin
      for (int k = 0; k < NumFma; k++) begin
        vld_q[k][0] <= vld_in[k];
        for (int s = 1; s < FmaLat; s++) vld_q[k][s] <= vld_q[k][s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int k = 0; k < NumFma; k++) begin
        side_q[k][0] <= side_in[k];
        for (int s = 1; s < FmaLat; s++) side_q[k][s] <= side_q[k][s-1];
      end
    end
  end

  // special arguments override the datapath result
  logic [31:0] xa, y_d;
  always_comb begin
    xa = side_out[NumFma-1].x;
    priority if (xa[30:0] > F_PINF[30:0]) begin
      y_d = xa | F_QNAN_BIT;
    end else if (xa > F_ZERO_CUT) begin
      y_d = 32'd0;
    end else if (!xa[31] && (xa > F_INF_CUT)) begin
      y_d = F_PINF;
    end else begin
      y_d = res[NumFma-1];
    end
  end

  logic        out_vld_q;
  logic [31:0] out_y_q;
  logic        out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ce) begin
      out_vld_q <= vld_q[NumFma-1][FmaLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      out_y_q    <= y_d;
      out_last_q <= side_out[NumFma-1].last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_y_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== hdl/f32e_fma.sv =====
// Pipelined binary32 fused multiply-add, round to nearest even, subnormals kept.
// Six register stages, global clock enable. Uses f32e_pkg.
module f32e_fma (
  input  logic        clk_i,
  input  logic        ce_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  output logic [31:0] z_o
);
  import f32e_pkg::*;

  function automatic logic [5:0] top_bit(input logic [62:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 1; i < 63; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  // ---- stage 1: unpack and multiply
  logic        [23:0] ma, mb, mc;
  logic signed [9:0]  ea, eb, ec;
  logic        [47:0] mp1_q;
  logic signed [10:0] ep1_q;
  logic        [23:0] mc1_q;
  logic signed [9:0]  ec1_q;
  logic               sp1_q, sc1_q, zp1_q, zc1_q;
  logic        [31:0] c1_q;

  always_comb begin
    ma = {|a_i[30:23], a_i[22:0]};
    mb = {|b_i[30:23], b_i[22:0]};
    mc = {|c_i[30:23], c_i[22:0]};
    ea = (a_i[30:23] == 8'd0) ? -10'sd149 : $signed({2'b00, a_i[30:23]}) - 10'sd150;
    eb = (b_i[30:23] == 8'd0) ? -10'sd149 : $signed({2'b00, b_i[30:23]}) - 10'sd150;
    ec = (c_i[30:23] == 8'd0) ? -10'sd149 : $signed({2'b00, c_i[30:23]}) - 10'sd150;
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      mp1_q <= ma * mb;
      ep1_q <= {ea[9], ea} + {eb[9], eb};
      mc1_q <= mc;
      ec1_q <= ec;
      sp1_q <= a_i[31] ^ b_i[31];
      sc1_q <= c_i[31];
      zp1_q <= (ma == 24'd0) || (mb == 24'd0);
      zc1_q <= (mc == 24'd0);
      c1_q  <= c_i;
    end
  end

  // ---- stage 2: normalize both addends to bit 61
  logic        [5:0]  lp, lc;
  logic        [61:0] mp2_q, mc2_q;
  logic signed [11:0] ep2_q, ec2_q;
  logic               sp2_q, sc2_q, zp2_q, zc2_q;
  logic        [31:0] c2_q;

  always_comb begin
    lp = 6'd61 - top_bit({15'd0, mp1_q});
    lc = 6'd61 - top_bit({39'd0, mc1_q});
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      mp2_q <= {14'd0, mp1_q} << lp;
      mc2_q <= {38'd0, mc1_q} << lc;
      ep2_q <= {ep1_q[10], ep1_q} - $signed({6'd0, lp});
      ec2_q <= {{2{ec1_q[9]}}, ec1_q} - $signed({6'd0, lc});
      sp2_q <= sp1_q;
      sc2_q <= sc1_q;
      zp2_q <= zp1_q;
      zc2_q <= zc1_q;
      c2_q  <= c1_q;
    end
  end

  // ---- stage 3: align smaller addend with sticky, add or subtract
  logic signed [12:0]  diff, dabs;
  logic                pbig;
  logic        [6:0]   dsh;
  logic        [61:0]  mbig, msml;
  logic        [123:0] ext;
  logic        [62:0]  sm, sum;
  logic        [62:0]  r3_q;
  logic signed [11:0]  e3_q;
  logic                s3_q, rz3_q, sp3_q, sc3_q, zp3_q, zc3_q;
  logic        [31:0]  c3_q;

  always_comb begin
    diff = {ep2_q[11], ep2_q} - {ec2_q[11], ec2_q};
    pbig = zc2_q || (diff > 13'sd0) || ((diff == 13'sd0) && (mp2_q >= mc2_q));
    dabs = pbig ? diff : -diff;
    // far-apart addend collapses to a sticky bit at position 0
    dsh  = ((dabs < 13'sd0) || (dabs > 13'sd123)) ? 7'd123 : dabs[6:0];
    mbig = pbig ? mp2_q : mc2_q;
    msml = pbig ? mc2_q : mp2_q;
    ext  = {msml, 62'd0} >> dsh;
    sm   = {1'b0, ext[123:62]} | {62'd0, |ext[61:0]};
    sum  = (sp2_q == sc2_q) ? {1'b0, mbig} + sm : {1'b0, mbig} - sm;
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      r3_q  <= sum;
      e3_q  <= pbig ? ep2_q : ec2_q;
      s3_q  <= pbig ? sp2_q : sc2_q;
      rz3_q <= (sum == 63'd0);
      sp3_q <= sp2_q;
      sc3_q <= sc2_q;
      zp3_q <= zp2_q;
      zc3_q <= zc2_q;
      c3_q  <= c2_q;
    end
  end

  // ---- stage 4: leading one and rounding shift amount
  logic signed [11:0] sh, lim;
  logic        [62:0] r4_q;
  logic signed [11:0] e4_q, sh4_q;
  logic               s4_q, rz4_q, sp4_q, sc4_q, zp4_q, zc4_q;
  logic        [31:0] c4_q;

  always_comb begin
    sh  = $signed({6'd0, top_bit(r3_q)}) - 12'sd23;
    lim = -12'sd149 - e3_q;
    if (lim > sh) sh = lim;
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      r4_q  <= r3_q;
      e4_q  <= e3_q;
      sh4_q <= sh;
      s4_q  <= s3_q;
      rz4_q <= rz3_q;
      sp4_q <= sp3_q;
      sc4_q <= sc3_q;
      zp4_q <= zp3_q;
      zc4_q <= zc3_q;
      c4_q  <= c3_q;
    end
  end

  // ---- stage 5: shift to 24 bits, collect guard and sticky
  logic        [11:0]  nsh;
  logic        [6:0]   rsh;
  logic        [62:0]  lsh;
  logic        [126:0] ext2;
  logic        [23:0]  q;
  logic                grd, stk;
  logic        [23:0]  q5_q;
  logic                inc5_q;
  logic signed [11:0]  be5_q;
  logic                s5_q, rz5_q, sp5_q, sc5_q, zp5_q, zc5_q;
  logic        [31:0]  c5_q;

  always_comb begin
    nsh  = 12'(-sh4_q);
    rsh  = (sh4_q > 12'sd64) ? 7'd64 : sh4_q[6:0];
    lsh  = r4_q << nsh[4:0];
    ext2 = {r4_q, 64'd0} >> rsh;
    if (sh4_q <= 12'sd0) begin
      q   = lsh[23:0];
      grd = 1'b0;
      stk = 1'b0;
    end else begin
      q   = ext2[87:64];
      grd = ext2[63];
      stk = |ext2[62:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      q5_q   <= q;
      inc5_q <= grd && (stk || q[0]);
      be5_q  <= e4_q + sh4_q + 12'sd149;
      s5_q   <= s4_q;
      rz5_q  <= rz4_q;
      sp5_q  <= sp4_q;
      sc5_q  <= sc4_q;
      zp5_q  <= zp4_q;
      zc5_q  <= zc4_q;
      c5_q   <= c4_q;
    end
  end

  // ---- stage 6: round, pack, special operands
  logic [24:0] qr;
  logic [31:0] bits, z_d, z_q;

  always_comb begin
    qr   = {1'b0, q5_q} + {24'd0, inc5_q};
    bits = {1'b0, be5_q[7:0], 23'd0} + {7'd0, qr};
    if (bits >= F_PINF) bits = F_PINF;
    priority if (zp5_q) begin
      z_d = zc5_q ? ((sp5_q && sc5_q) ? F_NEG_ZERO : 32'd0) : c5_q;
    end else if (rz5_q) begin
      z_d = 32'd0;
    end else if (be5_q >= 12'sd255) begin
      z_d = {s5_q, 31'd0} | F_PINF;
    end else begin
      z_d = {s5_q, 31'd0} | bits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) z_q <= z_d;
  end

  assign z_o = z_q;

endmodule

// ===== hdl/f32e_chk.sv =====
// Port-level checker for f32_exp_poly5, attached by bind.
// Depends only on the top level's ports.
module f32e_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // input side stalls exactly while a result waits
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("tready does not follow output stall");

  // no result right after reset
  a_rst: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("result out of reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

  // a NaN argument in the output slot would have been quieted
  a_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[30:23] == 8'hFF) && (m_axis_tdata[22:0] != 23'd0))
      |-> m_axis_tdata[22])
    else $error("signaling NaN on output");

endmodule

bind f32_exp_poly5 f32e_chk u_f32e_chk (.*);
